// ===== hdl/glyph_line_wrap_placer_defines.svh =====
// Assertion macros for the glyph placer.
`ifndef GLYPH_LINE_WRAP_PLACER_DEFINES_SVH
`define GLYPH_LINE_WRAP_PLACER_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define GLWP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define GLWP_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/glwp_pkg.sv =====
package glwp_pkg;

	localparam logic [1:0] REQ_HOME  = 2'd0;
	localparam logic [1:0] REQ_ADD   = 2'd1;
	localparam logic [1:0] REQ_FLUSH = 2'd2;

	localparam logic [2:0] CFG_LINE_START_X  = 3'd0;
	localparam logic [2:0] CFG_FIRST_BASE_Y  = 3'd1;
	localparam logic [2:0] CFG_LINE_PITCH    = 3'd2;
	localparam logic [2:0] CFG_LETTER_GAP    = 3'd3;
	localparam logic [2:0] CFG_MAX_WIDTH     = 3'd4;
	localparam logic [2:0] CFG_BLANK_CODE    = 3'd5;

	localparam logic RESP_ANSWER = 1'b0;
	localparam logic RESP_FLUSH  = 1'b1;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [15:0]        glyph_code;
		logic signed [15:0] offset_x;
		logic signed [15:0] offset_y;
		logic signed [15:0] advance_x;
		logic signed [15:0] advance_y;
	} req_t;

	typedef struct packed {
		logic               resp_kind;
		logic               line_break;
		logic               glyph_stored;
		logic               buffer_full;
		logic               glyph_valid;
		logic signed [15:0] glyph_x;
		logic signed [15:0] glyph_y;
		logic [15:0]        glyph_out_code;
		logic               last_item;
		logic [6:0]         committed_count;
	} rsp_t;

	// 26.6 to whole pixels, truncating toward zero.
	function automatic logic [15:0] div64(input logic [15:0] v);
		logic [15:0] q;
		q = {{6{v[15]}}, v[15:6]};
		if (v[15] && (v[5:0] != 6'd0)) begin
			q = q + 16'd1;
		end
		return q;
	endfunction

	function automatic rsp_t make_rsp(input logic kind, input logic brk, input logic st,
		input logic full, input logic valid, input logic [15:0] x, input logic [15:0] y,
		input logic [15:0] code, input logic last, input logic [6:0] cc);
		rsp_t r;
		r.resp_kind       = kind;
		r.line_break      = brk;
		r.glyph_stored    = st;
		r.buffer_full     = full;
		r.glyph_valid     = valid;
		r.glyph_x         = x;
		r.glyph_y         = y;
		r.glyph_out_code  = code;
		r.last_item       = last;
		r.committed_count = cc;
		return r;
	endfunction

endpackage

// ===== hdl/glyph_line_wrap_placer.sv =====
// Channel   | Signals                                  | Dir | Beat taken when
// request   | start, busy, req (glwp_pkg::req_t)       | in  | start && !busy
// result    | rsp_valid, rsp (glwp_pkg::rsp_t)         | out | rsp_valid (one cycle)
// config    | cfg_valid, cfg_ready, cfg_index, cfg_data| in  | cfg_valid && cfg_ready
//
// Home, unknown, plain add and empty flush requests finish in the accept cycle;
// the result is registered and shows in the next cycle. A word move steps through
// S_MV_A, S_MV_B, then S_MV_R/S_MV_W per moved glyph; a flush S_FL_R/S_FL_O per
// emitted glyph and S_CP_R/S_CP_W per leftover glyph; the buffer read is registered.
// Reset sets the pen, counts and config registers to defaults; the buffer is not cleared.
// Results cannot be stalled: each beat is valid for exactly one cycle.
module glyph_line_wrap_placer #(
	parameter int GLYPH_SLOTS = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  glwp_pkg::req_t   req,
	output logic             rsp_valid,
	output glwp_pkg::rsp_t   rsp,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [2:0]       cfg_index,
	input  logic [15:0]      cfg_data
);
	`include "glyph_line_wrap_placer_defines.svh"

	localparam int AW = (GLYPH_SLOTS > 1) ? $clog2(GLYPH_SLOTS) : 1;
	localparam int CW = $clog2(GLYPH_SLOTS + 1);
	localparam logic [CW-1:0] SLOTS_C = CW'(GLYPH_SLOTS);

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_MV_A = 9'b000000010,
		S_MV_B = 9'b000000100,
		S_MV_R = 9'b000001000,
		S_MV_W = 9'b000010000,
		S_FL_R = 9'b000100000,
		S_FL_O = 9'b001000000,
		S_CP_R = 9'b010000000,
		S_CP_W = 9'b100000000
	} state_t;

	state_t state_q;

	// configuration
	logic signed [15:0] lsx_q, fby_q;
	logic [9:0]         pitch_q;
	logic signed [7:0]  gap_q;
	logic [14:0]        maxw_q;
	logic [15:0]        blank_q;

	// line state
	logic [15:0]   pen_x_q, pen_y_q;
	logic [CW-1:0] stored_q, commit_q;
	logic          line_open_q, word_ok_q, wrap_q;
	logic [AW-1:0] word_slot_q, saved_q;
	logic [15:0]   dx_q;
	logic [CW-1:0] i_q, emit_q, left_q;

	logic           rsp_valid_q;
	glwp_pkg::rsp_t rsp_q;

	// glyph buffer: {x, y, code}
	logic [47:0]   mem [GLYPH_SLOTS];
	logic          wr_en;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [47:0]   wr_data, rd_data_q;

	logic        accept, blank, lead_space, full, add_go, ovf;
	logic [15:0] ox64, oy64, ax64, ay64, gx, gy, npx, npy;
	logic signed [17:0] lim;
	logic [CW-1:0] emit_c, left_c, stored_inc, src;
	logic [6:0]    cc7;

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign cc7       = 7'(commit_q);

	always_comb begin
		ox64 = glwp_pkg::div64(req.offset_x);
		oy64 = glwp_pkg::div64(req.offset_y);
		ax64 = glwp_pkg::div64(req.advance_x);
		ay64 = glwp_pkg::div64(req.advance_y);
		gx   = pen_x_q + ox64;
		gy   = pen_y_q - oy64;
		npx  = pen_x_q + ax64 + {{8{gap_q[7]}}, gap_q};
		npy  = pen_y_q + ay64;
		lim  = {{2{lsx_q[15]}}, lsx_q} + {3'b000, maxw_q};
		ovf  = !($signed({{2{npx[15]}}, npx}) < lim);
		blank      = (req.glyph_code == blank_q);
		lead_space = blank && !line_open_q;
		full       = (stored_q >= SLOTS_C);
		add_go     = accept && (req.req_type == glwp_pkg::REQ_ADD) && !lead_space && !full;
		stored_inc = stored_q + CW'(1);
		emit_c     = (commit_q < stored_q) ? commit_q : stored_q;
		left_c     = (stored_q > commit_q) ? (stored_q - commit_q) : '0;
		src        = commit_q + i_q;
	end

	// buffer port control
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = stored_q[AW-1:0];
		wr_data = {gx, gy, req.glyph_code};
		rd_addr = i_q[AW-1:0];
		unique case (state_q)
			S_IDLE: wr_en = add_go;
			S_MV_A: rd_addr = saved_q;
			S_MV_W: begin
				wr_en   = 1'b1;
				wr_addr = i_q[AW-1:0];
				wr_data = {rd_data_q[47:32] + dx_q, rd_data_q[31:16] + {6'b0, pitch_q},
					rd_data_q[15:0]};
			end
			S_CP_R: rd_addr = src[AW-1:0];
			S_CP_W: begin
				wr_en   = 1'b1;
				wr_addr = i_q[AW-1:0];
				wr_data = rd_data_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lsx_q   <= '0;
			fby_q   <= '0;
			pitch_q <= 10'd16;
			gap_q   <= '0;
			maxw_q  <= 15'd640;
			blank_q <= 16'd32;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				glwp_pkg::CFG_LINE_START_X: lsx_q   <= cfg_data;
				glwp_pkg::CFG_FIRST_BASE_Y: fby_q   <= cfg_data;
				glwp_pkg::CFG_LINE_PITCH:   pitch_q <= cfg_data[9:0];
				glwp_pkg::CFG_LETTER_GAP:   gap_q   <= cfg_data[7:0];
				glwp_pkg::CFG_MAX_WIDTH:    maxw_q  <= cfg_data[14:0];
				glwp_pkg::CFG_BLANK_CODE:   blank_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pen_x_q     <= '0;
			pen_y_q     <= 16'd16;
			stored_q    <= '0;
			commit_q    <= '0;
			line_open_q <= 1'b0;
			word_ok_q   <= 1'b0;
			word_slot_q <= '0;
			wrap_q      <= 1'b0;
			saved_q     <= '0;
			dx_q        <= '0;
			i_q         <= '0;
			emit_q      <= '0;
			left_q      <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			rsp_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						rsp_valid_q <= 1'b1;
						rsp_q <= glwp_pkg::make_rsp(glwp_pkg::RESP_ANSWER, 1'b0, 1'b0, 1'b0,
							1'b0, '0, '0, '0, 1'b1, cc7);
						case (req.req_type)
							glwp_pkg::REQ_HOME: begin
								// pen to the start of the first line, buffer empty
								pen_x_q     <= lsx_q;
								pen_y_q     <= fby_q + {6'b0, pitch_q};
								stored_q    <= '0;
								commit_q    <= '0;
								line_open_q <= 1'b0;
								word_ok_q   <= 1'b0;
								wrap_q      <= 1'b0;
								rsp_q.committed_count <= '0;
							end
							glwp_pkg::REQ_ADD: begin
								if (full && !lead_space) begin
									rsp_q.buffer_full <= 1'b1;
								end else if (add_go) begin
									stored_q    <= stored_inc;
									commit_q    <= stored_inc;
									line_open_q <= 1'b1;
									pen_x_q     <= npx;
									pen_y_q     <= npy;
									rsp_q.glyph_stored    <= 1'b1;
									rsp_q.committed_count <= 7'(stored_inc);
									if (blank) begin
										word_ok_q <= 1'b0;
									end else if (!word_ok_q) begin
										word_ok_q   <= 1'b1;
										word_slot_q <= stored_q[AW-1:0];
									end
									if (ovf) begin
										if (!blank) begin
											// word still open: break at the next space
											wrap_q <= 1'b1;
										end else if (wrap_q && word_ok_q) begin
											// move the last word down; answer when done
											wrap_q      <= 1'b0;
											commit_q    <= CW'(word_slot_q);
											saved_q     <= word_slot_q;
											pen_y_q     <= npy + {6'b0, pitch_q};
											rsp_valid_q <= 1'b0;
											state_q     <= S_MV_A;
										end else begin
											// plain break at this space
											wrap_q      <= 1'b0;
											pen_x_q     <= lsx_q;
											pen_y_q     <= npy + {6'b0, pitch_q};
											line_open_q <= 1'b0;
											rsp_q.line_break <= 1'b1;
										end
									end
								end
							end
							glwp_pkg::REQ_FLUSH: begin
								if (emit_c == '0) begin
									rsp_q.resp_kind <= glwp_pkg::RESP_FLUSH;
									stored_q <= left_c;
									commit_q <= left_c;
								end else begin
									rsp_valid_q <= 1'b0;
									emit_q  <= emit_c;
									left_q  <= left_c;
									i_q     <= '0;
									state_q <= S_FL_R;
								end
							end
							default: ;
						endcase
					end
				end
				S_MV_A: state_q <= S_MV_B;
				S_MV_B: begin
					dx_q    <= lsx_q - rd_data_q[47:32];
					pen_x_q <= pen_x_q + (lsx_q - rd_data_q[47:32]);
					i_q     <= CW'(saved_q);
					if (CW'(saved_q) + CW'(1) < stored_q) begin
						state_q <= S_MV_R;
					end else begin
						rsp_valid_q <= 1'b1;
						rsp_q <= glwp_pkg::make_rsp(glwp_pkg::RESP_ANSWER, 1'b1, 1'b1, 1'b0,
							1'b0, '0, '0, '0, 1'b1, cc7);
						state_q <= S_IDLE;
					end
				end
				S_MV_R: state_q <= S_MV_W;
				S_MV_W: begin
					i_q <= i_q + CW'(1);
					if (i_q + CW'(2) < stored_q) begin
						state_q <= S_MV_R;
					end else begin
						rsp_valid_q <= 1'b1;
						rsp_q <= glwp_pkg::make_rsp(glwp_pkg::RESP_ANSWER, 1'b1, 1'b1, 1'b0,
							1'b0, '0, '0, '0, 1'b1, cc7);
						state_q <= S_IDLE;
					end
				end
				S_FL_R: state_q <= S_FL_O;
				S_FL_O: begin
					rsp_valid_q <= 1'b1;
					rsp_q <= glwp_pkg::make_rsp(glwp_pkg::RESP_FLUSH, 1'b0, 1'b0, 1'b0, 1'b1,
						rd_data_q[47:32], rd_data_q[31:16], rd_data_q[15:0],
						(i_q + CW'(1) == emit_q), cc7);
					if (i_q + CW'(1) != emit_q) begin
						i_q     <= i_q + CW'(1);
						state_q <= S_FL_R;
					end else if (left_q != '0) begin
						// keep the leftover glyphs: copy them down to slot 0
						i_q     <= '0;
						state_q <= S_CP_R;
					end else begin
						stored_q <= '0;
						commit_q <= '0;
						state_q  <= S_IDLE;
					end
				end
				S_CP_R: state_q <= S_CP_W;
				S_CP_W: begin
					i_q <= i_q + CW'(1);
					if (i_q + CW'(1) == left_q) begin
						stored_q <= left_q;
						commit_q <= left_q;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_CP_R;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`GLWP_ASSERT_ALWAYS(a_count_bound, stored_q <= SLOTS_C, "stored count above buffer size")
	`GLWP_ASSERT(a_accept_moves, accept |=> (busy || rsp_valid), "accepted request vanished")
	`GLWP_ASSERT(a_answer_single, (rsp_valid && rsp.resp_kind == glwp_pkg::RESP_ANSWER) |-> rsp.last_item, "answer beat without last mark")

endmodule

// ===== bench/glyph_line_wrap_placer_checker.sv =====
module glyph_line_wrap_placer_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           busy,
	input  glwp_pkg::req_t req,
	input  logic           rsp_valid,
	input  glwp_pkg::rsp_t rsp,
	input  logic           cfg_valid,
	input  logic           cfg_ready,
	input  logic [2:0]     cfg_index,
	input  logic [15:0]    cfg_data,
	output int             fails,
	output int             pending
);
	import glwp_pkg::*;

	localparam int SLOTS   = 64;
	localparam int NO_SLOT = -1;

	// register copies
	int          line_x0, base_y0, pitch, letter_gap, width_max;
	int unsigned blank_code;

	// placement state
	int pen_x, pen_y, stored, committed, line_slot, word_slot;
	bit wrap_due;
	int          slot_x [SLOTS];
	int          slot_y [SLOTS];
	int unsigned slot_code [SLOTS];

	rsp_t placed_q[$];

	function automatic int w16(input int v);
		logic signed [15:0] t;
		t = v[15:0];
		return t;
	endfunction

	function automatic rsp_t beat(input logic kind, input logic brk, input logic st,
		input logic full, input logic valid, input int x, input int y,
		input int unsigned code, input logic last, input int cc);
		rsp_t r;
		r.resp_kind       = kind;
		r.line_break      = brk;
		r.glyph_stored    = st;
		r.buffer_full     = full;
		r.glyph_valid     = valid;
		r.glyph_x         = x[15:0];
		r.glyph_y         = y[15:0];
		r.glyph_out_code  = code[15:0];
		r.last_item       = last;
		r.committed_count = cc[6:0];
		return r;
	endfunction

	task automatic pen_home();
		pen_x     = line_x0;
		pen_y     = w16(base_y0 + pitch);
		stored    = 0;
		committed = 0;
		line_slot = NO_SLOT;
		word_slot = NO_SLOT;
		wrap_due  = 1'b0;
	endtask

	task automatic place_glyph(input req_t r);
		int idx, saved, dx, i, ox, oy, ax, ay;
		bit blank, brk;
		ox    = r.offset_x;
		oy    = r.offset_y;
		ax    = r.advance_x;
		ay    = r.advance_y;
		blank = (r.glyph_code == blank_code[15:0]);
		saved = NO_SLOT;
		brk   = 1'b0;
		// drop a space that would open a line
		if (blank && line_slot == NO_SLOT) begin
			placed_q.push_back(beat(RESP_ANSWER, 0, 0, 0, 0, 0, 0, 0, 1, committed));
			return;
		end
		if (stored >= SLOTS) begin
			placed_q.push_back(beat(RESP_ANSWER, 0, 0, 1, 0, 0, 0, 0, 1, committed));
			return;
		end
		idx            = stored;
		stored         = stored + 1;
		committed      = stored;
		slot_x[idx]    = w16(pen_x + ox / 64);
		slot_y[idx]    = w16(pen_y - oy / 64);
		slot_code[idx] = r.glyph_code;
		pen_x          = w16(pen_x + ax / 64 + letter_gap);
		pen_y          = w16(pen_y + ay / 64);
		if (line_slot == NO_SLOT) begin
			line_slot = idx;
		end
		if (blank) begin
			saved     = word_slot;
			word_slot = NO_SLOT;
		end else if (word_slot == NO_SLOT) begin
			word_slot = idx;
		end
		if (pen_x >= line_x0 + width_max) begin
			if (word_slot != NO_SLOT) begin
				wrap_due = 1'b1;
			end else begin
				brk = 1'b1;
				if (wrap_due && saved >= 0 && saved < SLOTS) begin
					// carry the last word over to the next line
					wrap_due  = 1'b0;
					committed = saved;
					dx        = line_x0 - slot_x[saved];
					for (i = saved; i < stored - 1; i++) begin
						slot_x[i] = w16(slot_x[i] + dx);
						slot_y[i] = w16(slot_y[i] + pitch);
					end
					pen_x = w16(pen_x + dx);
				end else begin
					wrap_due  = 1'b0;
					pen_x     = line_x0;
					committed = stored;
					line_slot = NO_SLOT;
				end
				pen_y = w16(pen_y + pitch);
			end
		end
		placed_q.push_back(beat(RESP_ANSWER, brk, 1, 0, 0, 0, 0, 0, 1, committed));
	endtask

	task automatic flush_line();
		int emit, left, i;
		emit = (committed < stored) ? committed : stored;
		left = stored - committed;
		if (emit < 0) begin
			emit = 0;
		end
		if (emit == 0) begin
			placed_q.push_back(beat(RESP_FLUSH, 0, 0, 0, 0, 0, 0, 0, 1, committed));
		end
		for (i = 0; i < emit; i++) begin
			placed_q.push_back(beat(RESP_FLUSH, 0, 0, 0, 1, slot_x[i], slot_y[i],
				slot_code[i], i == emit - 1, committed));
		end
		if (left < 0) begin
			left = 0;
		end
		// shift leftover glyphs down to slot zero
		if (committed > 0) begin
			for (i = 0; i < left; i++) begin
				if (committed + i < SLOTS) begin
					slot_x[i]    = slot_x[committed + i];
					slot_y[i]    = slot_y[committed + i];
					slot_code[i] = slot_code[committed + i];
				end
			end
		end
		stored    = left;
		committed = left;
	endtask

	task automatic check_beat(input rsp_t a);
		rsp_t e;
		if (placed_q.size() == 0) begin
			if (fails < 10) begin
				$display("unexpected result beat %p", a);
			end
			fails++;
			return;
		end
		e = placed_q.pop_front();
		if (a.resp_kind !== e.resp_kind || a.line_break !== e.line_break ||
			a.glyph_stored !== e.glyph_stored || a.buffer_full !== e.buffer_full ||
			a.glyph_valid !== e.glyph_valid || a.glyph_x !== e.glyph_x ||
			a.glyph_y !== e.glyph_y || a.glyph_out_code !== e.glyph_out_code ||
			a.last_item !== e.last_item || a.committed_count !== e.committed_count) begin
			if (fails < 10) begin
				$display("result mismatch\n  expected %p\n  actual   %p", e, a);
			end
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_x0    = 0;
			base_y0    = 0;
			pitch      = 16;
			letter_gap = 0;
			width_max  = 640;
			blank_code = 32;
			fails      = 0;
			placed_q.delete();
			pen_home();
		end else begin
			if (rsp_valid) begin
				check_beat(rsp);
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_LINE_START_X: line_x0 = w16(cfg_data);
					CFG_FIRST_BASE_Y: base_y0 = w16(cfg_data);
					CFG_LINE_PITCH:   pitch = cfg_data[9:0];
					CFG_LETTER_GAP:   letter_gap = $signed(cfg_data[7:0]);
					CFG_MAX_WIDTH:    width_max = cfg_data[14:0];
					CFG_BLANK_CODE:   blank_code = cfg_data;
					default: ;
				endcase
			end
			if (start && !busy) begin
				case (req.req_type)
					REQ_HOME: begin
						pen_home();
						placed_q.push_back(beat(RESP_ANSWER, 0, 0, 0, 0, 0, 0, 0, 1, committed));
					end
					REQ_ADD:   place_glyph(req);
					REQ_FLUSH: flush_line();
					default:
						placed_q.push_back(beat(RESP_ANSWER, 0, 0, 0, 0, 0, 0, 0, 1, committed));
				endcase
			end
		end
		pending = placed_q.size();
	end
endmodule

// ===== bench/glyph_line_wrap_placer_test.sv =====
module glyph_line_wrap_placer_test;
	import glwp_pkg::*;

	localparam int DRAIN_CYCLES = 400;
	localparam int STALL_LIMIT  = 20000;

	// request code the block does not know
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	req_t        req = '0;
	logic        rsp_valid;
	rsp_t        rsp;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	int          fails, pending;
	int          quiet_cycles = 0;
	bit          idling_on = 1'b1;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	glyph_line_wrap_placer DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.rsp_valid(rsp_valid), .rsp(rsp), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	glyph_line_wrap_placer_checker placement_check (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.rsp_valid(rsp_valid), .rsp(rsp), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .fails(fails), .pending(pending)
	);

	// Watchdog: any beat on any channel counts as progress.
	always @(posedge clk) begin
		if ((start && !busy) || rsp_valid || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Hold start low for a random gap while idling_on is set, then offer one request
	// beat and hold it until the block takes it. Returns at the falling edge after the beat.
	task automatic issue(input req_t r);
		while (idling_on && $urandom_range(99) < 27) begin
			start = 1'b0;
			@(negedge clk);
		end
		start = 1'b1;
		req   = r;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		start     = 1'b0;
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Drop start and wait for every expected beat, plus the block's tail work.
	task automatic settle();
		start = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic req_t glyph(input logic [15:0] code, input logic [15:0] ox,
		input logic [15:0] oy, input logic [15:0] ax, input logic [15:0] ay);
		req_t r;
		r.req_type   = REQ_ADD;
		r.glyph_code = code;
		r.offset_x   = ox;
		r.offset_y   = oy;
		r.advance_x  = ax;
		r.advance_y  = ay;
		return r;
	endfunction

	function automatic req_t op_only(input logic [1:0] kind);
		req_t r;
		r          = '0;
		r.req_type = kind;
		return r;
	endfunction

	// Mostly words of plain glyphs separated by the blank code, with
	// moderate advances so lines fill and wrap; some flushes, homes and noise.
	function automatic req_t random_req(input logic [15:0] blank);
		req_t r;
		int   pick;
		pick = $urandom_range(99);
		r    = glyph(16'($urandom), 16'($urandom_range(0, 640) - 320),
			16'($urandom_range(0, 640) - 320), 16'($urandom_range(0, 1600)), 16'd0);
		if (pick < 10) begin
			r = op_only(REQ_FLUSH);
		end else if (pick < 13) begin
			r = op_only(REQ_HOME);
		end else if (pick < 15) begin
			r = op_only(REQ_UNUSED);
			r.glyph_code = 16'($urandom);
		end else if (pick < 40) begin
			r.glyph_code = blank;
		end else if (pick < 50) begin
			r.offset_x  = 16'($urandom);
			r.offset_y  = 16'($urandom);
			r.advance_x = 16'($urandom);
			r.advance_y = 16'($urandom);
		end
		return r;
	endfunction

	task automatic random_phase(input int count, input logic [15:0] blank);
		int i;
		for (i = 0; i < count; i++) begin
			idling_on = !(i >= count / 3 && i < count / 3 + 25);
			issue(random_req(blank));
		end
		idling_on = 1'b1;
		settle();
	endtask

	initial begin
		int i;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Fill every buffer slot once so later word moves never touch an
		// unwritten entry; the last add hits a full buffer.
		for (i = 0; i <= 64; i++) begin
			issue(glyph(16'(16'h0041 + i), 16'($urandom), 16'($urandom), 16'd0,
				16'($urandom)));
		end
		issue(op_only(REQ_FLUSH));
		issue(op_only(REQ_HOME));

		// Directed: leading space, truncation of negative offsets, field extremes,
		// wrap at a space, last-word move, empty flush, unknown request.
		issue(glyph(16'd32, 0, 0, 16'd640, 0));
		issue(op_only(REQ_FLUSH));
		issue(glyph(16'hFFFF, 16'h8000, 16'h7FFF, 16'hFFC1, 16'hFFFF));
		issue(glyph(16'h0000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF));
		issue(op_only(REQ_HOME));
		issue(glyph(16'd65, 16'hFFFF, 16'hFFBF, 16'd12800, 0));
		issue(glyph(16'd66, 0, 0, 16'd12800, 0));
		issue(glyph(16'd32, 0, 0, 16'd6400, 0));
		issue(glyph(16'd67, 0, 0, 16'd6400, 0));
		issue(glyph(16'd68, 0, 0, 16'd12800, 0));
		issue(glyph(16'd32, 0, 0, 16'd6400, 0));
		issue(op_only(REQ_FLUSH));
		issue(op_only(REQ_FLUSH));
		issue(op_only(REQ_UNUSED));
		issue(glyph(16'd32, 0, 0, 16'd40960, 0));
		issue(op_only(REQ_FLUSH));
		issue(op_only(REQ_HOME));
		settle();

		random_phase(50, 16'd32);

		// Extremes of every register.
		write_reg(CFG_LINE_START_X, 16'h8000);
		write_reg(CFG_FIRST_BASE_Y, 16'h7FFF);
		write_reg(CFG_LINE_PITCH, 16'd1023);
		write_reg(CFG_LETTER_GAP, 16'h0080);
		write_reg(CFG_MAX_WIDTH, 16'h7FFF);
		write_reg(CFG_BLANK_CODE, 16'hFFFF);
		issue(op_only(REQ_HOME));
		random_phase(45, 16'hFFFF);

		write_reg(CFG_LINE_START_X, 16'h7FFF);
		write_reg(CFG_FIRST_BASE_Y, 16'h8000);
		write_reg(CFG_LINE_PITCH, 16'd0);
		write_reg(CFG_LETTER_GAP, 16'h007F);
		write_reg(CFG_MAX_WIDTH, 16'd1);
		write_reg(CFG_BLANK_CODE, 16'd0);
		issue(op_only(REQ_HOME));
		random_phase(24, 16'd0);

		write_reg(CFG_LINE_START_X, 16'($urandom_range(0, 200) - 100));
		write_reg(CFG_FIRST_BASE_Y, 16'($urandom));
		write_reg(CFG_LINE_PITCH, 16'($urandom_range(1, 40)));
		write_reg(CFG_LETTER_GAP, 16'($urandom_range(0, 6)));
		write_reg(CFG_MAX_WIDTH, 16'($urandom_range(100, 400)));
		write_reg(CFG_BLANK_CODE, 16'd32);
		issue(op_only(REQ_HOME));
		random_phase(24, 16'd32);

		if (fails == 0 && pending == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end
endmodule
